### rtl/fblr_pkg.sv
// Shared constants, command codes and controller/datapath interface types for the line rasterizer.
package fblr_pkg;

    // Framebuffer storage and coordinate sizing.
    localparam int FB_BYTES    = 32768;
    localparam int FB_ADDR_W   = $clog2(FB_BYTES);
    localparam int COORD_WIDTH = 10;

    // Fixed field widths of the command and result beats.
    localparam int KIND_W  = 2;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 15;
    localparam int DIM_W   = 11;
    localparam int COUNT_W = 11;
    localparam int ROT_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Internal arithmetic widths.
    localparam int ERR_W  = COORD_WIDTH + 3;
    localparam int MAP_W  = ((COORD_WIDTH + 1 > DIM_W) ? COORD_WIDTH + 1 : DIM_W) + 2;
    localparam int RB_W   = DIM_W - 2;
    localparam int CALC_W = 20;
    localparam int CNT_W  = $clog2(FB_BYTES + 1);

    // Command kinds.
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_HEIGHT = 2'd2;

    // Rotation codes.
    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // Configuration reset values.
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd272;

    // Panel seam: logical coordinates past this point (at or past it, but for rotation 0) skip a gap of columns.
    localparam int SEAM_POS = 396;
    localparam int SEAM_GAP = 8;

    localparam logic [COLOR_W-1:0] PIX_MSB_MASK = 8'h80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted command beat
        logic plot_step;   // map the current pixel and advance the line walk
        logic mem_rd_pix;  // read the byte under the mapped pixel
        logic mem_wr_pix;  // write back the modified pixel byte
        logic mem_rd_cmd;  // read the byte named by a read command
        logic clr_setup;   // compute the number of bytes to fill
        logic fill_step;   // write one fill byte
        logic present;     // drive the result fields
    } fblr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic line_done;   // the pixel just mapped is the last of the line
        logic clear_end;   // every byte of the clear area is written
    } fblr_sts_t;

endpackage

### rtl/fblr_ctrl.sv
// Command sequencer for the line rasterizer: accepts commands and steps the datapath.
module fblr_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [fblr_pkg::KIND_W-1:0] kind,
    input  fblr_pkg::fblr_sts_t      sts,
    output fblr_pkg::fblr_cmd_t      cmd,
    output logic                     busy,
    output logic                     done
);
    import fblr_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_L_ADDR  = 3'd1;
    localparam logic [2:0] ST_L_READ  = 3'd2;
    localparam logic [2:0] ST_L_WRITE = 3'd3;
    localparam logic [2:0] ST_C_SETUP = 3'd4;
    localparam logic [2:0] ST_C_FILL  = 3'd5;
    localparam logic [2:0] ST_R_READ  = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (kind)
                        KIND_LINE:  state_next = ST_L_ADDR;
                        KIND_CLEAR: state_next = ST_C_SETUP;
                        KIND_READ:  state_next = ST_R_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_L_ADDR:
            begin
                cmd.plot_step = 1'b1;
                state_next    = ST_L_READ;
            end
            ST_L_READ:
            begin
                cmd.mem_rd_pix = 1'b1;
                state_next     = ST_L_WRITE;
            end
            ST_L_WRITE:
            begin
                // The write-back of this pixel overlaps the mapping of the next one.
                cmd.mem_wr_pix = 1'b1;
                if (sts.line_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.plot_step = 1'b1;
                    state_next    = ST_L_READ;
                end
            end
            ST_C_SETUP:
            begin
                cmd.clr_setup = 1'b1;
                state_next    = ST_C_FILL;
            end
            ST_C_FILL:
            begin
                if (sts.clear_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_R_READ:
            begin
                cmd.mem_rd_cmd = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.present = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

### rtl/fblr_datapath.sv
// Datapath of the line rasterizer: settings, line walk, pixel mapping and framebuffer memory.
module fblr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fblr_pkg::fblr_cmd_t           cmd,
    output fblr_pkg::fblr_sts_t           sts,
    input  logic                          cfg_we,
    input  logic [fblr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fblr_pkg::DIM_W-1:0]    cfg_data,
    input  logic [fblr_pkg::KIND_W-1:0]   kind,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] x_start,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] y_start,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] x_end,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] y_end,
    input  logic [fblr_pkg::COLOR_W-1:0]  color,
    input  logic [fblr_pkg::ADDR_W-1:0]   address,
    output logic [fblr_pkg::COLOR_W-1:0]  read_data,
    output logic [fblr_pkg::COUNT_W-1:0]  plotted_count
);
    import fblr_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Settings.
    logic [ROT_W-1:0] rotation_reg;
    logic [DIM_W-1:0] mem_width_reg;
    logic [DIM_W-1:0] mem_height_reg;

    // Command state.
    logic [KIND_W-1:0]  kind_reg,  kind_next;
    logic [CW-1:0]      x_reg,     x_next;
    logic [CW-1:0]      y_reg,     y_next;
    logic [CW-1:0]      x1_reg,    x1_next;
    logic [CW-1:0]      y1_reg,    y1_next;
    logic signed [ERR_W-1:0] dx_reg,  dx_next;
    logic signed [ERR_W-1:0] dy_reg,  dy_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic               sx_neg_reg, sx_neg_next;
    logic               sy_neg_reg, sy_neg_next;
    logic               set_reg,   set_next;
    logic [COLOR_W-1:0] fill_reg,  fill_next;
    logic [FB_ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               line_done_reg, line_done_next;
    logic signed [MAP_W-1:0] map_mx_reg, map_mx_next;
    logic signed [MAP_W-1:0] map_my_reg, map_my_next;
    logic               map_ok_reg, map_ok_next;
    logic [FB_ADDR_W-1:0] pix_addr_reg, pix_addr_next;
    logic [COLOR_W-1:0] pix_mask_reg, pix_mask_next;
    logic               pix_valid_reg, pix_valid_next;
    logic [CNT_W-1:0]   clr_total_reg, clr_total_next;
    logic [CNT_W-1:0]   clr_cnt_reg,   clr_cnt_next;
    logic [COLOR_W-1:0] rdata_reg;

    // Load-time line setup.
    logic signed [ERR_W-1:0] x0_s, y0_s, x1_s, y1_s, dx_ld, dy_ld;
    logic [CALC_W-1:0] rd_full;

    // Pixel mapping.
    logic [CW:0]   lx_seam, ly_seam;
    logic signed [MAP_W-1:0] w_s, h_s, lx_s, ly_s, mx, my;
    logic [DIM_W:0]   rb_sum;
    logic [RB_W-1:0]  row_bytes;
    logic [DIM_W-1:0] mul_b;
    logic [CALC_W-1:0] mul_p, addr_full;
    logic in_range;

    // Line walk step.
    logic signed [ERR_W:0] e2a, e2b, dx_w, dy_w;
    logic signed [ERR_W-1:0] err_a;
    logic step_x, step_y, stop_x, stop_y;
    logic [CW-1:0] x_adv, y_adv;

    // Memory ports.
    logic [COLOR_W-1:0] mem [FB_BYTES];
    logic                 mem_we, mem_re;
    logic [FB_ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [COLOR_W-1:0]   mem_wdata;

    // Seam shift and rotation of the current logical pixel into memory coordinates.
    always_comb
    begin
        lx_seam = {1'b0, x_reg};
        ly_seam = {1'b0, y_reg};
        case (rotation_reg)
            ROT_0:
            begin
                if ({1'b0, x_reg} > (CW + 1)'(SEAM_POS))
                    lx_seam = {1'b0, x_reg} + (CW + 1)'(SEAM_GAP);
            end
            ROT_180:
            begin
                if ({1'b0, x_reg} >= (CW + 1)'(SEAM_POS))
                    lx_seam = {1'b0, x_reg} + (CW + 1)'(SEAM_GAP);
            end
            default:
            begin
                if ({1'b0, y_reg} >= (CW + 1)'(SEAM_POS))
                    ly_seam = {1'b0, y_reg} + (CW + 1)'(SEAM_GAP);
            end
        endcase

        w_s  = signed'(MAP_W'(mem_width_reg));
        h_s  = signed'(MAP_W'(mem_height_reg));
        lx_s = signed'(MAP_W'(lx_seam));
        ly_s = signed'(MAP_W'(ly_seam));

        case (rotation_reg)
            ROT_0:
            begin
                mx = lx_s;
                my = ly_s;
            end
            ROT_90:
            begin
                mx = w_s - ly_s - MAP_W'(1);
                my = lx_s;
            end
            ROT_180:
            begin
                mx = w_s - lx_s - MAP_W'(1);
                my = h_s - ly_s - MAP_W'(1);
            end
            default:
            begin
                mx = ly_s;
                my = h_s - lx_s - MAP_W'(1);
            end
        endcase

        in_range = (mx >= 0) && (my >= 0) && (mx < w_s) && (my < h_s);
    end

    // Bytes per row, and one multiplier shared by pixel addressing and clear sizing.
    // The byte address is formed from the registered memory coordinates, in the read cycle.
    assign rb_sum    = {1'b0, mem_width_reg} + (DIM_W + 1)'(7);
    assign row_bytes = rb_sum[DIM_W:3];
    assign mul_b     = cmd.clr_setup ? mem_height_reg : map_my_reg[DIM_W-1:0];
    assign mul_p     = CALC_W'(row_bytes) * CALC_W'(mul_b);
    assign addr_full = mul_p + CALC_W'(map_mx_reg[DIM_W-1:3]);

    // One step of the line walk. The second test sees the error already updated by the first.
    always_comb
    begin
        dx_w  = {dx_reg[ERR_W-1], dx_reg};
        dy_w  = {dy_reg[ERR_W-1], dy_reg};
        e2a   = {err_reg, 1'b0};
        step_x = (e2a >= dy_w);
        stop_x = step_x && (x_reg == x1_reg);
        err_a = (step_x && !stop_x) ? err_reg + dy_reg : err_reg;
        e2b   = {err_a, 1'b0};
        step_y = !stop_x && (e2b <= dx_w);
        stop_y = step_y && (y_reg == y1_reg);
        x_adv = sx_neg_reg ? x_reg - CW'(1) : x_reg + CW'(1);
        y_adv = sy_neg_reg ? y_reg - CW'(1) : y_reg + CW'(1);
    end

    // Command setup values.
    always_comb
    begin
        x0_s  = signed'(ERR_W'(x_start));
        y0_s  = signed'(ERR_W'(y_start));
        x1_s  = signed'(ERR_W'(x_end));
        y1_s  = signed'(ERR_W'(y_end));
        dx_ld = (x1_s >= x0_s) ? x1_s - x0_s : x0_s - x1_s;
        dy_ld = (y1_s >= y0_s) ? y0_s - y1_s : y1_s - y0_s;
        rd_full = CALC_W'(address);
    end

    always_comb
    begin
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        err_next       = err_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        set_next       = set_reg;
        fill_next      = fill_reg;
        rd_addr_next   = rd_addr_reg;
        rd_ok_next     = rd_ok_reg;
        count_next     = count_reg;
        line_done_next = line_done_reg;
        map_mx_next    = map_mx_reg;
        map_my_next    = map_my_reg;
        map_ok_next    = map_ok_reg;
        pix_addr_next  = pix_addr_reg;
        pix_mask_next  = pix_mask_reg;
        pix_valid_next = pix_valid_reg;
        clr_total_next = clr_total_reg;
        clr_cnt_next   = clr_cnt_reg;

        if (cmd.load)
        begin
            kind_next    = kind;
            x_next       = x_start;
            y_next       = y_start;
            x1_next      = x_end;
            y1_next      = y_end;
            dx_next      = dx_ld;
            dy_next      = dy_ld;
            err_next     = dx_ld + dy_ld;
            sx_neg_next  = !(x_start < x_end);
            sy_neg_next  = !(y_start < y_end);
            set_next     = (color != '0);
            fill_next    = color;
            rd_addr_next = rd_full[FB_ADDR_W-1:0];
            rd_ok_next   = (rd_full < CALC_W'(FB_BYTES));
            count_next   = '0;
        end

        if (cmd.plot_step)
        begin
            count_next     = count_reg + COUNT_W'(1);
            map_mx_next    = mx;
            map_my_next    = my;
            map_ok_next    = in_range;
            line_done_next = stop_x || stop_y;
            err_next       = (step_y && !stop_y) ? err_a + dx_reg : err_a;
            if (step_x && !stop_x)
                x_next = x_adv;
            if (step_y && !stop_y)
                y_next = y_adv;
        end

        if (cmd.mem_rd_pix)
        begin
            pix_addr_next  = addr_full[FB_ADDR_W-1:0];
            pix_mask_next  = PIX_MSB_MASK >> map_mx_reg[2:0];
            pix_valid_next = map_ok_reg && (addr_full < CALC_W'(FB_BYTES));
        end

        if (cmd.clr_setup)
        begin
            clr_cnt_next   = '0;
            clr_total_next = (mul_p >= CALC_W'(FB_BYTES)) ? CNT_W'(FB_BYTES)
                                                          : mul_p[CNT_W-1:0];
        end

        if (cmd.fill_step)
        begin
            clr_cnt_next = clr_cnt_reg + CNT_W'(1);
        end
    end

    // Settings registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg   <= ROT_0;
            mem_width_reg  <= WIDTH_RESET;
            mem_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROTATION:   rotation_reg   <= cfg_data[ROT_W-1:0];
                CFG_MEM_WIDTH:  mem_width_reg  <= cfg_data;
                CFG_MEM_HEIGHT: mem_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Working registers; the controller never uses them before it loads them.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        err_reg       <= err_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        set_reg       <= set_next;
        fill_reg      <= fill_next;
        rd_addr_reg   <= rd_addr_next;
        rd_ok_reg     <= rd_ok_next;
        count_reg     <= count_next;
        line_done_reg <= line_done_next;
        map_mx_reg    <= map_mx_next;
        map_my_reg    <= map_my_next;
        map_ok_reg    <= map_ok_next;
        pix_addr_reg  <= pix_addr_next;
        pix_mask_reg  <= pix_mask_next;
        pix_valid_reg <= pix_valid_next;
        clr_total_reg <= clr_total_next;
        clr_cnt_reg   <= clr_cnt_next;
    end

    // Framebuffer: one write and one registered read per cycle.
    assign mem_we    = (cmd.mem_wr_pix && pix_valid_reg) || cmd.fill_step;
    assign mem_waddr = cmd.fill_step ? clr_cnt_reg[FB_ADDR_W-1:0] : pix_addr_reg;
    assign mem_wdata = cmd.fill_step ? fill_reg
                     : (set_reg ? (rdata_reg | pix_mask_reg) : (rdata_reg & ~pix_mask_reg));
    assign mem_re    = cmd.mem_rd_pix || cmd.mem_rd_cmd;
    assign mem_raddr = cmd.mem_rd_cmd ? rd_addr_reg : addr_full[FB_ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    assign sts.line_done = line_done_reg;
    assign sts.clear_end = (clr_cnt_reg >= clr_total_reg);

    assign read_data     = (cmd.present && (kind_reg == KIND_READ) && rd_ok_reg)
                         ? rdata_reg : '0;
    assign plotted_count = (cmd.present && (kind_reg == KIND_LINE)) ? count_reg : '0;

endmodule

### rtl/framebuffer_line_rasterizer_core.sv
// Top level of the 1-bit-per-pixel framebuffer line rasterizer.
//
// Commands enter on start/busy: a command beat is taken at a rising edge where start
// is high and busy is low. Kind selects draw line, clear buffer or read byte; kind 3
// does nothing but still returns a zeroed result. Each command yields exactly one
// result beat, shown for one cycle with done high: read_data carries the byte of a
// read command and plotted_count the pixel count of a line, both zero otherwise.
// The receiver cannot stall, so results are never held back.
//
// A line is drawn with one read-modify-write of the framebuffer per pixel (the
// mapping of the next pixel overlaps the write-back of the current one). A clear
// writes one byte per cycle, and a read goes through the registered memory read.
// busy drops in the cycle after done, and a new command can then be taken.
//
// The settings port writes rotation, width and height on any edge with cfg_we high;
// it should only be used while busy is low. Reset restores rotation 0 and an 800 by
// 272 panel and idles the sequencer; the framebuffer contents are not cleared, so
// software issues a clear command before drawing.
module framebuffer_line_rasterizer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [fblr_pkg::KIND_W-1:0]      kind,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] x_start,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] y_start,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] x_end,
    input  logic [fblr_pkg::COORD_WIDTH-1:0] y_end,
    input  logic [fblr_pkg::COLOR_W-1:0]     color,
    input  logic [fblr_pkg::ADDR_W-1:0]      address,
    output logic                             done,
    output logic [fblr_pkg::COLOR_W-1:0]     read_data,
    output logic [fblr_pkg::COUNT_W-1:0]     plotted_count,
    input  logic                             cfg_we,
    input  logic [fblr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fblr_pkg::DIM_W-1:0]       cfg_data
);
    import fblr_pkg::*;

    // The sequencer drives the datapath by one command word per cycle and
    // watches two status flags that end the line walk and the fill sweep.
    fblr_cmd_t cmd;
    fblr_sts_t sts;

    fblr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fblr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .x_start       (x_start),
        .y_start       (y_start),
        .x_end         (x_end),
        .y_end         (y_end),
        .color         (color),
        .address       (address),
        .read_data     (read_data),
        .plotted_count (plotted_count)
    );

endmodule

### rtl/fblr_checker.sv
// Port-level assertions for the line rasterizer core, bound to the top level.
module fblr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [fblr_pkg::COLOR_W-1:0] read_data,
    input logic [fblr_pkg::COUNT_W-1:0] plotted_count
);
    import fblr_pkg::*;

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A result beat only appears while a command is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    // Each result beat lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for more than one cycle");

    // The block returns to idle only right after delivering a result.
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result beat");

    // A line result never carries read data.
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (plotted_count != '0)) |-> (read_data == '0))
        else $error("both result fields nonzero");

endmodule

bind framebuffer_line_rasterizer_core fblr_checker u_fblr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .read_data     (read_data),
    .plotted_count (plotted_count)
);
